// File: rtl/pitch_timed_gate_unit_assert.svh
// Assertion macros used by the top module to check its own logic.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef PITCH_TIMED_GATE_UNIT_ASSERT_SVH
`define PITCH_TIMED_GATE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ptg_pkg.sv
package ptg_pkg;

  // Block dimensions.
  localparam int CHANNELS  = 16;
  localparam int TIME_BITS = 40;
  localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths fixed by the interface.
  localparam int CH_W   = 4;
  localparam int VOLT_W = 16;
  localparam int ST_W   = 24;

  // Pitch to length arithmetic: 2048 steps per octave, Q30 factors.
  localparam int N_FRAC   = 11;
  localparam int FRAC_W   = 32;
  localparam int Q_FRAC   = 30;
  localparam int MUL_W    = 64;
  localparam int C4_W     = 24;
  localparam int PROD_W   = 56;
  localparam int SHIFT_W  = VOLT_W + 1 - N_FRAC;
  localparam int TSUM_W   = TIME_BITS + 1;

  // Front pipeline: input stage, one stage per fraction bit, product,
  // rounding add and final shift.
  localparam int ST_PROD  = N_FRAC + 1;
  localparam int ST_RND   = N_FRAC + 2;
  localparam int ST_LEN   = N_FRAC + 3;
  localparam int PIPE_LEN = N_FRAC + 4;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [MUL_W-1:0]   mul_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [SHIFT_W-1:0] shift_t;
  typedef logic [TSUM_W-1:0]  tsum_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [1:0]         reg_idx_t;

  localparam reg_idx_t REG_SAMPLE_TIME   = 2'd0;
  localparam reg_idx_t REG_ON_THRESHOLD  = 2'd1;
  localparam reg_idx_t REG_OFF_THRESHOLD = 2'd2;

  localparam logic [ST_W-1:0]          SAMPLE_TIME_RST   = 24'd89478;
  localparam logic signed [VOLT_W-1:0] ON_THRESHOLD_RST  = 16'sd2048;
  localparam logic signed [VOLT_W-1:0] OFF_THRESHOLD_RST = 16'sd0;

  localparam logic [C4_W-1:0]      C4_PERIOD  = 24'd16416466;
  localparam logic [FRAC_W-1:0]    Q30_ONE    = 32'h4000_0000;
  localparam logic [FRAC_W-1:0]    Q30_HALF   = 32'h2000_0000;
  localparam shift_t               SHIFT_BASE = 6'd30;
  localparam logic [TIME_BITS-1:0] TIME_MAX   = '1;

  typedef logic [N_FRAC-1:0][FRAC_W-1:0] frac_tab_t;

  // Integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bit_v;
    x     = x_in;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= res + bit_v) begin
        x   = x - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Entry b holds 2^(2^b/2048) in Q30; each lower entry is the square root
  // of the one above it.
  function automatic frac_tab_t build_frac_table();
    frac_tab_t   t;
    logic [63:0] r;
    r = isqrt64(64'd2 << 60);
    t[N_FRAC-1] = r[FRAC_W-1:0];
    for (int i = N_FRAC - 2; i >= 0; i--) begin
      r = isqrt64({32'b0, t[i+1]} << Q_FRAC);
      t[i] = r[FRAC_W-1:0];
    end
    return t;
  endfunction

  localparam frac_tab_t FRAC_TABLE = build_frac_table();

  // Side information that travels alongside the length computation.
  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic                     served;
    logic signed [VOLT_W-1:0] trigger;
    shift_t                   shift;
  } tag_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic                     served;
    logic signed [VOLT_W-1:0] trigger;
    logic [TIME_BITS-1:0]     length;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [ST_W-1:0]          sample_time;
    logic signed [VOLT_W-1:0] on_threshold;
    logic signed [VOLT_W-1:0] off_threshold;
  } cfg_t;

endpackage

// File: rtl/ptg_chan_if.sv
interface ptg_in_if;
  logic                             valid;
  logic                             ready;
  logic [ptg_pkg::CH_W-1:0]         channel;
  logic signed [ptg_pkg::VOLT_W-1:0] pitch_volts;
  logic signed [ptg_pkg::VOLT_W-1:0] trigger_volts;

  modport source (output valid, channel, pitch_volts, trigger_volts, input ready);
  modport sink (input valid, channel, pitch_volts, trigger_volts, output ready);
endinterface

interface ptg_out_if;
  logic                     valid;
  logic                     ready;
  logic [ptg_pkg::CH_W-1:0] channel_out;
  logic                     gate;

  modport source (output valid, channel_out, gate, input ready);
  modport sink (input valid, channel_out, gate, output ready);
endinterface

// File: rtl/pitch_timed_gate_unit.sv
// Pitch timed gate for up to sixteen polyphonic channels.
// Input channel in_chan: one request per sample, carrying the channel number, the pitch
// voltage and the trigger voltage. Output channel out_chan: one request per input request,
// in the same order, carrying the channel number and the gate bit of that channel.
// Both channels use a valid/ready handshake; a request moves when both are high.
// The APB-style port sets the sample time and the two trigger thresholds; it should
// only be written while no requests are in flight.
// Throughput is one request per clock cycle while the output is not stalled. Every stage
// of the pitch pipeline holds at most one multiplier, and the per-channel state is read,
// updated and written back in the same cycle, so requests for the same channel may follow
// each other directly. A result passes through the 15 pipeline stages, the queue and the
// output register.
// Reset, synchronous and active low, marks every trigger high, so that it must fall to the
// off threshold before it can fire, closes every gate, empties the pipeline and the queue,
// and loads the register defaults (48 kHz sample time, on threshold 1 V, off threshold 0 V).
// When the receiver stalls, the result waits in the output register and the four-entry
// queue fills behind it; once the queue is full and a request reaches the end of the
// pitch pipeline, the whole pipeline holds and the input ready falls.
`include "pitch_timed_gate_unit_assert.svh"

module pitch_timed_gate_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  ptg_in_if.sink                      in_chan,
  ptg_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptg_pkg::ADDR_W-1:0]  paddr,
  input  logic [ptg_pkg::DATA_W-1:0]  pwdata,
  output logic [ptg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  // Configuration registers.
  logic [ptg_pkg::ST_W-1:0]           sample_time_r;
  logic [ptg_pkg::ST_W-1:0]           sample_time_nxt;
  logic signed [ptg_pkg::VOLT_W-1:0]  on_thr_r;
  logic signed [ptg_pkg::VOLT_W-1:0]  on_thr_nxt;
  logic signed [ptg_pkg::VOLT_W-1:0]  off_thr_r;
  logic signed [ptg_pkg::VOLT_W-1:0]  off_thr_nxt;
  logic                               wr_en;
  ptg_pkg::reg_idx_t                  reg_idx;
  ptg_pkg::cfg_t                      cfg;

  // Links between the front, the queue and the back.
  logic                               job_valid;
  ptg_pkg::job_t                      job;
  ptg_pkg::job_t                      q_head;
  ptg_pkg::qstat_t                    q_stat;
  logic                               q_pop;

  // Registers sit at byte addresses 0, 4 and 8; the low address bits are ignored.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ptg_pkg::ADDR_W-1:2];

  always_comb begin
    sample_time_nxt = sample_time_r;
    on_thr_nxt      = on_thr_r;
    off_thr_nxt     = off_thr_r;
    if (wr_en) begin
      case (reg_idx)
        ptg_pkg::REG_SAMPLE_TIME: begin
          sample_time_nxt = pwdata[ptg_pkg::ST_W-1:0];
        end
        ptg_pkg::REG_ON_THRESHOLD: begin
          on_thr_nxt = pwdata[ptg_pkg::VOLT_W-1:0];
        end
        ptg_pkg::REG_OFF_THRESHOLD: begin
          off_thr_nxt = pwdata[ptg_pkg::VOLT_W-1:0];
        end
        default: begin
          sample_time_nxt = sample_time_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_time_r <= ptg_pkg::SAMPLE_TIME_RST;
      on_thr_r      <= ptg_pkg::ON_THRESHOLD_RST;
      off_thr_r     <= ptg_pkg::OFF_THRESHOLD_RST;
    end else begin
      sample_time_r <= sample_time_nxt;
      on_thr_r      <= on_thr_nxt;
      off_thr_r     <= off_thr_nxt;
    end
  end

  // Reads return the stored value; the thresholds come back sign extended.
  always_comb begin
    case (reg_idx)
      ptg_pkg::REG_SAMPLE_TIME:   prdata = ptg_pkg::data_t'(sample_time_r);
      ptg_pkg::REG_ON_THRESHOLD:  prdata = ptg_pkg::data_t'(on_thr_r);
      ptg_pkg::REG_OFF_THRESHOLD: prdata = ptg_pkg::data_t'(off_thr_r);
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.sample_time   = sample_time_r;
    cfg.on_threshold  = on_thr_r;
    cfg.off_threshold = off_thr_r;
  end

  // The front accepts samples, marks whether the channel is served and works out
  // the gate length from the pitch, whether or not an edge will follow.
  ptg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .q_stat    (q_stat),
    .job_valid (job_valid),
    .job       (job)
  );

  // A short queue lets the front keep going while the output is briefly held.
  ptg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_valid),
    .push_job   (job),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  // The back runs the Schmitt trigger and the gate timer of each channel.
  ptg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .head     (q_head),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

  // A full queue must hold the whole front, input included.
  `PTG_ASSERT_NOW(a_full_stalls_input, job_valid && q_stat.full, !in_chan.ready, "input when full")
  // The back never takes from an empty queue.
  `PTG_ASSERT_NOW(a_pop_not_empty, q_pop, !q_stat.empty, "pop from empty queue")
  // Every request taken from the queue shows up as a result in the next cycle.
  `PTG_ASSERT_NEXT(a_pop_loads_output, q_pop, out_chan.valid, "popped request not presented")

endmodule

// File: rtl/ptg_front.sv
module ptg_front (
  input  logic            clk,
  input  logic            rst_n,
  ptg_in_if.sink          in_chan,
  input  ptg_pkg::qstat_t q_stat,
  output logic            job_valid,
  output ptg_pkg::job_t   job
);

  logic [ptg_pkg::PIPE_LEN-1:0]     vld_r;
  ptg_pkg::tag_t                    tag_r [ptg_pkg::PIPE_LEN];
  logic [ptg_pkg::N_FRAC-1:0]       f_r   [ptg_pkg::N_FRAC];
  logic [ptg_pkg::FRAC_W-1:0]       acc_r [ptg_pkg::N_FRAC+1];
  ptg_pkg::prod_t                   prod_r;
  ptg_pkg::prod_t                   rsum_r;
  logic [ptg_pkg::TIME_BITS-1:0]    len_r;

  logic                             adv;
  logic [ptg_pkg::VOLT_W:0]         q_neg;
  ptg_pkg::tag_t                    tag_in;
  ptg_pkg::mul_t                    mul_full [ptg_pkg::N_FRAC];
  ptg_pkg::mul_t                    mul_rnd  [ptg_pkg::N_FRAC];
  logic [ptg_pkg::FRAC_W-1:0]       acc_step [ptg_pkg::N_FRAC];
  ptg_pkg::prod_t                   half;
  ptg_pkg::prod_t                   shifted;
  logic [ptg_pkg::TIME_BITS-1:0]    len_sat;

  // The whole pipeline moves together unless the tail is held by a full queue.
  assign adv           = !vld_r[ptg_pkg::ST_LEN] || !q_stat.full;
  assign in_chan.ready = adv;

  always_comb begin
    // Octave count and fraction of the negated pitch.
    q_neg          = -{in_chan.pitch_volts[ptg_pkg::VOLT_W-1], in_chan.pitch_volts};
    tag_in.channel = in_chan.channel;
    tag_in.served  = int'(in_chan.channel) < ptg_pkg::CHANNELS;
    tag_in.trigger = in_chan.trigger_volts;
    tag_in.shift   = ptg_pkg::SHIFT_BASE - q_neg[ptg_pkg::VOLT_W:ptg_pkg::N_FRAC];
  end

  always_comb begin
    for (int k = 0; k < ptg_pkg::N_FRAC; k++) begin
      mul_full[k] = ptg_pkg::mul_t'(acc_r[k]) * ptg_pkg::mul_t'(ptg_pkg::FRAC_TABLE[k]);
      mul_rnd[k]  = mul_full[k] + ptg_pkg::mul_t'(ptg_pkg::Q30_HALF);
      acc_step[k] = mul_rnd[k][ptg_pkg::Q_FRAC+ptg_pkg::FRAC_W-1:ptg_pkg::Q_FRAC];
    end
  end

  always_comb begin
    half    = ptg_pkg::prod_t'(1) << (tag_r[ptg_pkg::ST_PROD].shift - ptg_pkg::shift_t'(1));
    shifted = rsum_r >> tag_r[ptg_pkg::ST_RND].shift;
    if (|shifted[ptg_pkg::PROD_W-1:ptg_pkg::TIME_BITS]) begin
      len_sat = ptg_pkg::TIME_MAX;
    end else begin
      len_sat = shifted[ptg_pkg::TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[ptg_pkg::PIPE_LEN-2:0], in_chan.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[0] <= tag_in;
      f_r[0]   <= q_neg[ptg_pkg::N_FRAC-1:0];
      acc_r[0] <= ptg_pkg::Q30_ONE;
      for (int s = 1; s < ptg_pkg::PIPE_LEN; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
      for (int k = 1; k < ptg_pkg::N_FRAC; k++) begin
        f_r[k] <= f_r[k-1];
      end
      for (int k = 0; k < ptg_pkg::N_FRAC; k++) begin
        acc_r[k+1] <= f_r[k][k] ? acc_step[k] : acc_r[k];
      end
      prod_r <= ptg_pkg::prod_t'(ptg_pkg::C4_PERIOD)
              * ptg_pkg::prod_t'(acc_r[ptg_pkg::N_FRAC]);
      rsum_r <= prod_r + half;
      len_r  <= len_sat;
    end
  end

  always_comb begin
    job_valid   = vld_r[ptg_pkg::ST_LEN];
    job.channel = tag_r[ptg_pkg::ST_LEN].channel;
    job.served  = tag_r[ptg_pkg::ST_LEN].served;
    job.trigger = tag_r[ptg_pkg::ST_LEN].trigger;
    job.length  = len_r;
  end

endmodule

// File: rtl/ptg_queue.sv
module ptg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  ptg_pkg::job_t   push_job,
  input  logic            pop,
  output ptg_pkg::job_t   head,
  output ptg_pkg::qstat_t stat
);

  ptg_pkg::job_t               mem_r [ptg_pkg::QDEPTH];
  logic [ptg_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [ptg_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [ptg_pkg::QCNT_W-1:0]  count_r;
  logic                        push;

  assign stat.full  = count_r == ptg_pkg::QCNT_W'(ptg_pkg::QDEPTH);
  assign stat.empty = count_r == '0;
  assign push       = push_valid && !stat.full;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/ptg_back.sv
module ptg_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ptg_pkg::cfg_t   cfg,
  input  ptg_pkg::job_t   head,
  input  ptg_pkg::qstat_t q_stat,
  output logic            pop,
  ptg_out_if.source       out_chan
);

  logic                          trig_high_r [ptg_pkg::CHANNELS];
  logic                          gate_open_r [ptg_pkg::CHANNELS];
  logic [ptg_pkg::TIME_BITS-1:0] elapsed_r   [ptg_pkg::CHANNELS];
  logic [ptg_pkg::TIME_BITS-1:0] length_r    [ptg_pkg::CHANNELS];

  logic                          out_valid_r;
  logic [ptg_pkg::CH_W-1:0]      out_channel_r;
  logic                          out_gate_r;

  ptg_pkg::idx_t                 idx;
  logic signed [ptg_pkg::VOLT_W-1:0] trig;
  logic signed [ptg_pkg::VOLT_W-1:0] on_thr;
  logic signed [ptg_pkg::VOLT_W-1:0] off_thr;
  logic                          th_cur;
  logic                          th_nxt;
  logic                          edge_det;
  logic [ptg_pkg::TIME_BITS-1:0] el_base;
  ptg_pkg::tsum_t                el_sum;
  logic [ptg_pkg::TIME_BITS-1:0] el_nxt;
  logic [ptg_pkg::TIME_BITS-1:0] len_nxt;
  logic                          open_nxt;
  logic                          gate_res;

  // Take the next request whenever the output register is free or draining.
  assign pop = !q_stat.empty && (!out_valid_r || out_chan.ready);

  always_comb begin
    idx      = ptg_pkg::idx_t'(head.channel);
    trig     = head.trigger;
    on_thr   = cfg.on_threshold;
    off_thr  = cfg.off_threshold;
    th_cur   = trig_high_r[idx];
    th_nxt   = th_cur;
    edge_det = 1'b0;
    if (th_cur) begin
      if (trig <= off_thr) begin
        th_nxt = 1'b0;
      end
    end else if (trig >= on_thr) begin
      th_nxt   = 1'b1;
      edge_det = 1'b1;
    end
    el_base = edge_det ? '0 : elapsed_r[idx];
    len_nxt = edge_det ? head.length : length_r[idx];
    el_sum  = {1'b0, el_base} + ptg_pkg::tsum_t'(cfg.sample_time);
    el_nxt  = el_sum[ptg_pkg::TIME_BITS] ? ptg_pkg::TIME_MAX : el_sum[ptg_pkg::TIME_BITS-1:0];
    open_nxt = (edge_det || gate_open_r[idx]) && (el_nxt < len_nxt);
    gate_res = head.served && open_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptg_pkg::CHANNELS; i++) begin
        trig_high_r[i] <= 1'b1;
        gate_open_r[i] <= 1'b0;
        elapsed_r[i]   <= '0;
        length_r[i]    <= '0;
      end
    end else if (pop && head.served) begin
      trig_high_r[idx] <= th_nxt;
      gate_open_r[idx] <= open_nxt;
      elapsed_r[idx]   <= el_nxt;
      length_r[idx]    <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_channel_r <= head.channel;
      out_gate_r    <= gate_res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.channel_out = out_channel_r;
  assign out_chan.gate        = out_gate_r;

endmodule

// File: tb/ptg_gate_check.sv
`timescale 1ns / 100ps

module ptg_gate_check
  import ptg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ptg_in_if                 in_mon,
  ptg_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  data_t             pwdata,
  input  data_t             prdata,
  input  logic              pready,
  output int                errors,
  output int                outstanding,
  output int                compared,
  output int                openings,
  output int                closings
);

  // Time is counted in 2^-32 s ticks; the C4 period is 2^32 / 261.6256.
  localparam longint unsigned C4_TICKS  = 64'd16416466;
  localparam longint unsigned Q30       = 64'd1 << 30;
  localparam longint unsigned TICKS_MAX = (64'd1 << TIME_BITS) - 1;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            gate;
  } gate_result_t;

  gate_result_t expected_gates[$];

  // Q30 values of 2^(2^b/2048), each the square root of the one above.
  longint unsigned root_steps[N_FRAC];

  logic                     armed_high    [CHANNELS];
  logic                     open_now      [CHANNELS];
  logic [TIME_BITS-1:0]     elapsed_ticks [CHANNELS];
  logic [TIME_BITS-1:0]     length_ticks  [CHANNELS];

  logic [ST_W-1:0]          step_ticks;
  logic signed [VOLT_W-1:0] on_level;
  logic signed [VOLT_W-1:0] off_level;

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      trial = r | (64'd1 << k);
      if (trial * trial <= x) r = trial;
    end
    return r;
  endfunction

  initial begin
    root_steps[N_FRAC-1] = floor_sqrt(64'd2 << 60);
    for (int i = N_FRAC - 2; i >= 0; i--)
      root_steps[i] = floor_sqrt(root_steps[i+1] << 30);
  end

  // Gate length for a pitch: the C4 period scaled by 2^(-pitch), the octave
  // handled as a shift and the fraction of an octave through the root table.
  function automatic logic [TIME_BITS-1:0] gate_period(logic signed [VOLT_W-1:0] pitch);
    int unsigned     down;
    int unsigned     frac;
    int              octave;
    int              sh;
    longint unsigned factor;
    longint unsigned scaled;
    longint unsigned len;
    down   = 65536 - int'(pitch);
    frac   = down & 2047;
    octave = int'(down >> 11) - 32;
    factor = Q30;
    for (int b = 0; b < N_FRAC; b++)
      if (frac[b]) factor = (factor * root_steps[b] + (Q30 >> 1)) >> 30;
    scaled = C4_TICKS * factor;
    sh     = 30 - octave;
    len    = (scaled + (64'd1 << (sh - 1))) >> sh;
    return (len > TICKS_MAX) ? TIME_BITS'(TICKS_MAX) : TIME_BITS'(len);
  endfunction

  // Runs one sample through the channel state and returns the gate bit.
  function automatic logic advance_channel(logic [CH_W-1:0] ch,
                                           logic signed [VOLT_W-1:0] pitch,
                                           logic signed [VOLT_W-1:0] trig);
    logic               rising;
    logic [TIME_BITS:0] sum;
    if (int'(ch) >= CHANNELS) return 1'b0;
    rising = 1'b0;
    if (armed_high[ch]) begin
      if (trig <= off_level) armed_high[ch] = 1'b0;
    end else if (trig >= on_level) begin
      armed_high[ch] = 1'b1;
      rising         = 1'b1;
    end
    if (rising) begin
      length_ticks[ch]  = gate_period(pitch);
      open_now[ch]      = 1'b1;
      elapsed_ticks[ch] = '0;
      openings++;
    end
    sum = {1'b0, elapsed_ticks[ch]} + (TIME_BITS + 1)'(step_ticks);
    elapsed_ticks[ch] = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
    if (open_now[ch] && elapsed_ticks[ch] >= length_ticks[ch]) begin
      open_now[ch] = 1'b0;
      closings++;
    end
    return open_now[ch];
  endfunction

  task automatic flag(string what, longint want_v, longint got_v);
    errors++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    gate_result_t want;
    gate_result_t got;
    int           pushed;
    int           popped;
    pushed = 0;
    popped = 0;
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        armed_high[i]    = 1'b1;
        open_now[i]      = 1'b0;
        elapsed_ticks[i] = '0;
        length_ticks[i]  = '0;
      end
      step_ticks = SAMPLE_TIME_RST;
      on_level   = ON_THRESHOLD_RST;
      off_level  = OFF_THRESHOLD_RST;
      expected_gates.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr >> 2))
            REG_SAMPLE_TIME:   step_ticks = pwdata[ST_W-1:0];
            REG_ON_THRESHOLD:  on_level   = pwdata[VOLT_W-1:0];
            REG_OFF_THRESHOLD: off_level  = pwdata[VOLT_W-1:0];
            default: ;
          endcase
        end else begin
          case (reg_idx_t'(paddr >> 2))
            REG_SAMPLE_TIME:
              if (prdata[ST_W-1:0] !== step_ticks)
                flag("sample time readback", step_ticks, prdata[ST_W-1:0]);
            REG_ON_THRESHOLD:
              if (prdata[VOLT_W-1:0] !== on_level)
                flag("on threshold readback", on_level, $signed(prdata[VOLT_W-1:0]));
            REG_OFF_THRESHOLD:
              if (prdata[VOLT_W-1:0] !== off_level)
                flag("off threshold readback", off_level, $signed(prdata[VOLT_W-1:0]));
            default: ;
          endcase
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        want.channel = in_mon.channel;
        want.gate    = advance_channel(in_mon.channel, in_mon.pitch_volts,
                                       in_mon.trigger_volts);
        expected_gates.push_back(want);
        pushed = 1;
      end

      if (out_mon.valid && out_mon.ready) begin
        got.channel = out_mon.channel_out;
        got.gate    = out_mon.gate;
        if (expected_gates.size() == 0) begin
          errors++;
          $display("%0t ns: result with none expected, channel %0d gate %0b",
                   $time, got.channel, got.gate);
        end else begin
          want   = expected_gates.pop_front();
          popped = 1;
          compared++;
          if (got.channel !== want.channel) flag("channel", want.channel, got.channel);
          if (got.gate !== want.gate) flag("gate", want.gate, got.gate);
        end
      end

      outstanding <= outstanding + pushed - popped;
    end
  end

endmodule

// File: tb/tb_pitch_timed_gate_unit.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the pitch timed gate. The checker beside the block
// watches both request channels and the register port, predicts every gate
// bit and counts mismatches; this module drives traffic, watches for hangs and reports.
module tb_pitch_timed_gate_unit;
  import ptg_pkg::*;

  // Cycles without any accepted request before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Samples held on one channel after the longest possible gate has opened.
  localparam int SOAK_SAMPLES = 40;
  localparam logic [CH_W-1:0] SOAK_CH = 4'd7;
  localparam int PHASE_SAMPLES = 180;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  data_t             pwdata;
  data_t             prdata;
  logic              pready;

  ptg_in_if  in_chan ();
  ptg_out_if out_chan ();

  int errors;
  int outstanding;
  int compared;
  int openings;
  int closings;
  int samples_sent;
  int settings_used;
  int idle_cycles;

  // When set, neither side inserts gaps, so requests run back to back.
  bit calm;
  // Most random requests land on a window of four channels so that gates
  // get the chance to run to their end.
  int chan_base;
  int on_now;
  int off_now;

  pitch_timed_gate_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ptg_gate_check gate_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .errors      (errors),
    .outstanding (outstanding),
    .compared    (compared),
    .openings    (openings),
    .closings    (closings)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VOLT_W-1:0] volts_between(int lo, int hi);
    if (lo > hi) lo = hi;
    return VOLT_W'(lo + $urandom_range(0, hi - lo));
  endfunction

  // Pitches are mostly chosen so that a gate lasts from under one sample to a
  // few dozen samples at the default rate; the rest cover the whole range.
  function automatic logic signed [VOLT_W-1:0] pick_pitch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return volts_between(4000, 16000);
    if (r < 75) return volts_between(-4000, 4000);
    return VOLT_W'($urandom);
  endfunction

  // The receiver stalls at random unless the run is calm. The ready line
  // gets exactly one assignment per clock edge.
  initial begin : result_drain
    int stall_left;
    stall_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Watchdog: any accepted request on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout after %0d cycles without a request moving.", STALL_LIMIT);
      $display("tb_pitch_timed_gate_unit: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One sample request. Valid stays high into the next request when no gap
  // is drawn, so it is never lowered and raised within the same step.
  task automatic send_sample(logic [CH_W-1:0] ch, logic signed [VOLT_W-1:0] pitch,
                             logic signed [VOLT_W-1:0] trig);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.channel       <= ch;
    in_chan.pitch_volts   <= pitch;
    in_chan.trigger_volts <= trig;
    do @(posedge clk); while (!in_chan.ready);
    samples_sent++;
  endtask

  // Random request of a loosely well-formed note stream: rearm levels, edge
  // levels and hold levels that keep the trigger armed, with some noise.
  task automatic random_sample();
    logic [CH_W-1:0]          ch;
    logic signed [VOLT_W-1:0] trig;
    int                       r;
    if ($urandom_range(0, 9) < 7) ch = CH_W'(chan_base + $urandom_range(0, 3));
    else ch = CH_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 20) trig = volts_between(-32768, off_now);
    else if (r < 40) trig = volts_between(on_now, 32767);
    else if (r < 85) trig = volts_between(off_now + 1, 32767);
    else trig = VOLT_W'($urandom);
    send_sample(ch, pick_pitch(), trig);
  endtask

  // A register access; transfers follow each other without an idle cycle,
  // and bus_idle closes a group of them.
  task automatic bus_transfer(bit wr, reg_idx_t idx, data_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic bus_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_all_registers();
    bus_transfer(1'b0, REG_SAMPLE_TIME, '0);
    bus_transfer(1'b0, REG_ON_THRESHOLD, '0);
    bus_transfer(1'b0, REG_OFF_THRESHOLD, '0);
    bus_idle();
  endtask

  // Registers change only with nothing in flight: every gate result of the
  // previous phase has come back before the first write.
  task automatic apply_setting(logic [ST_W-1:0] st, int on_v, int off_v);
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    bus_transfer(1'b1, REG_SAMPLE_TIME, data_t'(st));
    bus_transfer(1'b1, REG_ON_THRESHOLD, data_t'(on_v));
    bus_transfer(1'b1, REG_OFF_THRESHOLD, data_t'(off_v));
    read_all_registers();
    on_now  = on_v;
    off_now = off_v;
    settings_used++;
  endtask

  task automatic random_phase(logic [ST_W-1:0] st, int on_v, int off_v, bit quiet);
    apply_setting(st, on_v, off_v);
    calm      = quiet;
    chan_base = int'($urandom_range(0, CHANNELS - 4));
    repeat (PHASE_SAMPLES) random_sample();
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.channel       <= '0;
    in_chan.pitch_volts   <= '0;
    in_chan.trigger_volts <= '0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    samples_sent  = 0;
    settings_used = 1;
    calm          = 1'b0;
    chan_base     = 0;
    on_now        = int'(ON_THRESHOLD_RST);
    off_now       = int'(OFF_THRESHOLD_RST);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset values must read back before anything is written.
    read_all_registers();

    // Directed part at the reset settings: on at 1 V, off at 0 V, 48 kHz.
    // Trigger exactly at the off level rearms, one step under the on level
    // does nothing, exactly at the on level fires a middle C gate.
    send_sample(4'd0, 16'sh0000, 16'sh0000);
    send_sample(4'd0, 16'sh0000, 16'sd2047);
    send_sample(4'd0, 16'sh0000, 16'sd2048);
    send_sample(4'd0, 16'sh0000, 16'sh7FFF);
    // Lowest pitch gives the longest possible gate; the gate then stays open.
    send_sample(4'd15, 16'sh8000, 16'sh8000);
    send_sample(4'd15, 16'sh8000, 16'sh7FFF);
    send_sample(4'd15, 16'sh7FFF, 16'sd1);
    // Highest pitch gives a gate shorter than one sample, closed at once.
    send_sample(4'd10, 16'sh7FFF, -16'sd1);
    send_sample(4'd10, 16'sh7FFF, 16'sd2048);
    // Pitches one step either side of zero use one and all fraction bits.
    send_sample(4'd5, -16'sd1, 16'sh0000);
    send_sample(4'd5, -16'sd1, 16'sd4096);
    send_sample(4'd3, 16'sd1, 16'sh0000);
    send_sample(4'd3, 16'sd1, 16'sd2048);
    // A whole octave down, no fraction at all.
    send_sample(4'd6, -16'sd2048, -16'sd100);
    send_sample(4'd6, -16'sd2048, 16'sd10000);
    // Alternating bit patterns on pitch and trigger.
    send_sample(4'd9, 16'sh5555, 16'sh0000);
    send_sample(4'd9, 16'shAAAA, 16'sh7FFF);
    // Rearm while the gate is open, then retrigger with a gate of a few
    // samples and hold until it closes on time.
    send_sample(4'd0, 16'sh0000, 16'sh0000);
    send_sample(4'd0, 16'sd12000, 16'sd3000);
    repeat (4) send_sample(4'd0, 16'sh0000, 16'sd5000);

    // Random phases over a spread of settings: extremes of every register,
    // crossed thresholds, zero sample time, defaults and random values.
    random_phase(24'hFFFFFF, 32767, -32768, 1'b0);
    random_phase(24'd1, -32768, 32767, 1'b1);
    random_phase(24'd0, 1000, -1000, 1'b0);
    random_phase(SAMPLE_TIME_RST, int'(ON_THRESHOLD_RST), int'(OFF_THRESHOLD_RST), 1'b0);
    random_phase(ST_W'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20)),
                 int'(volts_between(-32768, 32767)), int'(volts_between(-32768, 32767)), 1'b0);
    random_phase(ST_W'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20)),
                 int'(volts_between(-8000, 8000)), int'(volts_between(-8000, 8000)), 1'b1);

    // Hold on one channel at the largest sample time after an edge with the
    // lowest pitch: even at this rate the longest gate must stay open.
    apply_setting(24'hFFFFFF, int'(ON_THRESHOLD_RST), int'(OFF_THRESHOLD_RST));
    calm = 1'b1;
    send_sample(SOAK_CH, 16'sh8000, -16'sd5);
    send_sample(SOAK_CH, 16'sh8000, 16'sd5000);
    repeat (SOAK_SAMPLES) send_sample(SOAK_CH, pick_pitch(), volts_between(1, 32767));

    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (24) @(posedge clk);

    $display("Covered %0d samples over %0d register settings, with a %0d-sample hold",
             samples_sent, settings_used, SOAK_SAMPLES);
    $display("on one channel; %0d gate results compared, %0d gates opened, %0d closed.",
             compared, openings, closings);
    if (errors == 0) begin
      $display("tb_pitch_timed_gate_unit: done, clean");
    end else begin
      $display("tb_pitch_timed_gate_unit: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ptg_pkg.sv
rtl/ptg_chan_if.sv
rtl/ptg_front.sv
rtl/ptg_queue.sv
rtl/ptg_back.sv
rtl/pitch_timed_gate_unit.sv
tb/ptg_gate_check.sv
tb/tb_pitch_timed_gate_unit.sv
